>>> design/escape_sequence_key_decoder_macros.svh
// assertion macros for the escape sequence key decoder
`ifndef ESCAPE_SEQUENCE_KEY_DECODER_MACROS_SVH
`define ESCAPE_SEQUENCE_KEY_DECODER_MACROS_SVH

// same-cycle implication, checked outside reset
`define ESCKD_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("escape key decoder: same-cycle check failed");

// next-cycle implication, checked outside reset
`define ESCKD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("escape key decoder: next-cycle check failed");

`endif

>>> design/esckd_pkg.sv
// shared types and character constants for the escape sequence key decoder
package esckd_pkg;

   // request kinds
   localparam logic REQ_BYTE    = 1'b0;
   localparam logic REQ_TIMEOUT = 1'b1;

   // characters of the sequences
   localparam logic [7:0] CH_ESC      = 8'h1B;
   localparam logic [7:0] CH_SS3      = 8'h4F;
   localparam logic [7:0] CH_CSI      = 8'h5B;
   localparam logic [7:0] CH_ARROW_LO = 8'h41;
   localparam logic [7:0] CH_ARROW_HI = 8'h44;
   localparam logic [7:0] CH_NUMLOCK  = 8'h50;
   localparam logic [7:0] CH_BACKTAB  = 8'h5A;
   localparam logic [7:0] CH_TILDE    = 8'h7E;
   localparam logic [7:0] CH_DIGIT_LO = 8'h31;
   localparam logic [7:0] CH_DIGIT_HI = 8'h36;
   localparam logic [7:0] CH_DIGIT_NO = 8'h33;

   // key codes
   localparam logic [7:0]  KEY_PREFIX   = 8'hFF;
   localparam logic [15:0] KEY_ESC      = 16'h001B;
   localparam logic [15:0] KEY_NUM_LOCK = 16'hFF50;

   // one decode outcome: a key to send or nothing
   typedef struct packed {
      logic        emit;
      logic [15:0] key_code;
   } result_type;

endpackage

>>> design/escape_sequence_key_decoder.sv
// top level: input register, sequence decoder and result register
//
//   channel | direction | handshake             | payload
//   req     | in        | req_valid / req_stall | req_type, req_rx_byte
//   rsp     | out       | rsp_valid / rsp_stall | rsp_key_code
//
// one transfer a cycle while req_stall is low; a key's last byte passes through the input register,
// then is decoded into the result register
// a byte or timeout that completes no key is consumed with no response
// synchronous reset returns the decoder to idle and empties both registers
// rsp_stall holds the result register, and req_stall rises while the input register is full
// and the result register is held by rsp_stall
`include "escape_sequence_key_decoder_macros.svh"

module escape_sequence_key_decoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_type,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_key_code
);

   logic                  s1_valid_ff;
   logic                  s1_type_ff;
   logic [7:0]            s1_byte_ff;
   logic                  advance;
   esckd_pkg::result_type decoded;
   esckd_pkg::result_type load;

   // held item moves on when the result register is free
   assign advance   = s1_valid_ff && (!rsp_valid || !rsp_stall);
   assign req_stall = s1_valid_ff && !advance;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         s1_type_ff <= req_type;
         s1_byte_ff <= req_rx_byte;
      end
   end

   esckd_parser u_parser (
      .clock    (clock),
      .reset    (reset),
      .step     (advance),
      .req_type (s1_type_ff),
      .rx_byte  (s1_byte_ff),
      .result   (decoded)
   );

   // only a processed item may load a key
   assign load.emit     = advance && decoded.emit;
   assign load.key_code = decoded.key_code;

   esckd_rsp_reg u_rsp_reg (
      .clock        (clock),
      .reset        (reset),
      .load         (load),
      .rsp_stall    (rsp_stall),
      .rsp_valid    (rsp_valid),
      .rsp_key_code (rsp_key_code)
   );

   // checks
   `ESCKD_ASSERT_NEXT(a_key_loaded, clock, reset, load.emit, rsp_valid)
   `ESCKD_ASSERT_NOW(a_stall_needs_item, clock, reset, req_stall, s1_valid_ff)
   `ESCKD_ASSERT_NOW(a_no_stall_when_free, clock, reset, !rsp_valid, !req_stall)
   `ESCKD_ASSERT_NEXT(a_input_drains, clock, reset, advance && !(req_valid && !req_stall),
                      !s1_valid_ff)

endmodule

>>> design/esckd_parser.sv
// sequence state machine and key decode for one received transfer
module esckd_parser (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      step,
   input  logic                      req_type,
   input  logic [7:0]                rx_byte,
   output esckd_pkg::result_type     result
);

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_ESC,
      PH_SS3,
      PH_CSI,
      PH_DIGIT
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [7:0]  held_ff, held_in;
   logic        is_final, is_digit;

   // byte classes
   assign is_final = ((rx_byte >= esckd_pkg::CH_ARROW_LO) && (rx_byte <= esckd_pkg::CH_ARROW_HI))
                     || (rx_byte == esckd_pkg::CH_NUMLOCK) || (rx_byte == esckd_pkg::CH_BACKTAB);
   assign is_digit = (held_ff >= esckd_pkg::CH_DIGIT_LO) && (held_ff <= esckd_pkg::CH_DIGIT_HI)
                     && (held_ff != esckd_pkg::CH_DIGIT_NO);

   // next phase and result
   always_comb begin
      phase_in        = PH_IDLE;
      held_in         = held_ff;
      result.emit     = 1'b0;
      result.key_code = esckd_pkg::KEY_ESC;
      unique case (phase_ff)
         PH_IDLE: begin
            if (req_type == esckd_pkg::REQ_BYTE) begin
               if (rx_byte == esckd_pkg::CH_ESC) begin
                  phase_in = PH_ESC;
               end else begin
                  result.emit     = 1'b1;
                  result.key_code = {8'h00, rx_byte};
               end
            end
         end
         PH_ESC: begin
            if (req_type == esckd_pkg::REQ_TIMEOUT) begin
               result.emit = 1'b1;
            end else if (rx_byte == esckd_pkg::CH_SS3) begin
               phase_in = PH_SS3;
            end else if (rx_byte == esckd_pkg::CH_CSI) begin
               phase_in = PH_CSI;
            end else begin
               result.emit = 1'b1;
            end
         end
         PH_SS3: begin
            result.emit = 1'b1;
            if ((req_type == esckd_pkg::REQ_BYTE) && (rx_byte == esckd_pkg::CH_NUMLOCK)) begin
               result.key_code = esckd_pkg::KEY_NUM_LOCK;
            end
         end
         PH_CSI: begin
            if (req_type == esckd_pkg::REQ_TIMEOUT) begin
               result.emit = 1'b1;
            end else if (is_final) begin
               result.emit     = 1'b1;
               result.key_code = {esckd_pkg::KEY_PREFIX, rx_byte};
            end else begin
               held_in  = rx_byte;
               phase_in = PH_DIGIT;
            end
         end
         PH_DIGIT: begin
            result.emit = 1'b1;
            if ((req_type == esckd_pkg::REQ_BYTE) && (rx_byte == esckd_pkg::CH_TILDE)
                && is_digit) begin
               result.key_code = {esckd_pkg::KEY_PREFIX, held_ff};
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   // state update on each processed transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         held_ff  <= 8'h00;
      end else if (step) begin
         phase_ff <= phase_in;
         held_ff  <= held_in;
      end
   end

endmodule

>>> design/esckd_rsp_reg.sv
// result register on the response channel
module esckd_rsp_reg (
   input  logic                      clock,
   input  logic                      reset,
   input  esckd_pkg::result_type     load,
   input  logic                      rsp_stall,
   output logic                      rsp_valid,
   output logic [15:0]               rsp_key_code
);

   logic        valid_ff;
   logic [15:0] key_ff;

   // load a new key or drop the one taken
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load.emit) begin
         valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         valid_ff <= 1'b0;
      end
   end

   // payload holds while stalled
   always_ff @(posedge clock) begin
      if (load.emit) begin
         key_ff <= load.key_code;
      end
   end

   assign rsp_valid    = valid_ff;
   assign rsp_key_code = key_ff;

endmodule
